/* src/tmc_pkg.sv */
`default_nettype none
package tmc_pkg;

	localparam int STORE_DEPTH = 64;

	localparam logic [7:0] FIRST_CELL      = 8'd5;
	localparam logic [7:0] LAST_CELL       = 8'd62;
	localparam logic [7:0] FLAG_BIT        = 8'h10;
	localparam logic [7:0] IDX_MASK        = 8'h0f;
	localparam logic [7:0] ERASED          = 8'hff;
	localparam logic [7:0] LVL_STROBE      = 8'd253;
	localparam logic [7:0] LVL_PROGRAM     = 8'd254;
	localparam logic [7:0] LVL_TURBO       = 8'd255;
	localparam logic [7:0] LVL_TURBO_LOW   = 8'd128;
	localparam logic [7:0] LVL_PROGRAM_OUT = 8'd51;
	localparam logic [7:0] LVL_FAST_MIN    = 8'd8;
	localparam logic [7:0] RAMP_LIMIT      = 8'd250;
	localparam logic [7:0] PROG_FIRST      = 8'd9;
	localparam logic [7:0] PROG_END        = 8'd14;
	localparam logic [7:0] LOCK_SECOND     = 8'd2;
	localparam logic [7:0] TICK_MAX        = 8'd255;
	localparam logic [7:0] CHECK_RELOAD    = 8'd225;
	localparam logic [7:0] BATT_CRIT       = 8'd120;
	localparam logic [7:0] BATT_LIMIT      = 8'd10;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPDOWN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STROBE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP     = 3'd4;

	localparam logic [1:0] KIND_STEADY  = 2'd0;
	localparam logic [1:0] KIND_STROBE  = 2'd1;
	localparam logic [1:0] KIND_PROGRAM = 2'd2;
	localparam logic [1:0] KIND_OFF     = 2'd3;

	typedef struct packed {
		logic [7:0] group_select;
		logic [7:0] memory_setting;
		logic [7:0] stepdown_setting;
		logic [7:0] strobe_period_setting;
		logic [7:0] ramp_setting;
	} tmc_cfg_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_NEXT,
		WR_POS,
		WR_PRESS
	} tmc_wr_t;

	typedef struct packed {
		logic    power_init;
		logic    scan;
		logic    press_rd;
		logic    press_ld;
		logic    decide;
		logic    tick;
		tmc_wr_t wr;
	} tmc_cmd_t;

	typedef struct packed {
		logic scan_done;
	} tmc_status_t;

	typedef struct packed {
		logic [7:0] output_level;
		logic       fast_pwm;
		logic [1:0] light_kind;
		logic [7:0] strobe_half_period;
		logic [2:0] program_slot;
	} tmc_result_t;

	function automatic logic [2:0] group_len(input logic [2:0] g);
		case (g)
			3'd2, 3'd3, 3'd6: group_len = 3'd4;
			3'd4:             group_len = 3'd5;
			3'd7:             group_len = 3'd1;
			default:          group_len = 3'd3;
		endcase
	endfunction

	// ramp slot of groups 3 and 4 reads as 0 here and is replaced by the custom level
	function automatic logic [7:0] group_level(input logic [2:0] g, input logic [2:0] i);
		logic [7:0] v;
		v = 8'd0;
		case (g)
			3'd2: begin
				case (i)
					3'd0: v = 8'd26;
					3'd1: v = 8'd128;
					3'd2: v = 8'd255;
					3'd3: v = 8'd253;
					default: v = 8'd0;
				endcase
			end
			3'd3: begin
				case (i)
					3'd1: v = 8'd26;
					3'd2: v = 8'd128;
					3'd3: v = 8'd255;
					default: v = 8'd0;
				endcase
			end
			3'd4: begin
				case (i)
					3'd1: v = 8'd18;
					3'd2: v = 8'd51;
					3'd3: v = 8'd153;
					3'd4: v = 8'd255;
					default: v = 8'd0;
				endcase
			end
			3'd5: begin
				case (i)
					3'd0: v = 8'd255;
					3'd1: v = 8'd128;
					3'd2: v = 8'd26;
					default: v = 8'd0;
				endcase
			end
			3'd6: begin
				case (i)
					3'd0: v = 8'd255;
					3'd1: v = 8'd128;
					3'd2: v = 8'd26;
					3'd3: v = 8'd253;
					default: v = 8'd0;
				endcase
			end
			3'd7: begin
				case (i)
					3'd0: v = 8'd255;
					default: v = 8'd0;
				endcase
			end
			default: begin
				case (i)
					3'd0: v = 8'd26;
					3'd1: v = 8'd128;
					3'd2: v = 8'd255;
					default: v = 8'd0;
				endcase
			end
		endcase
		group_level = v;
	endfunction

endpackage
`default_nettype wire

/* src/tmc_ctrl.sv */
`default_nettype none
module tmc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 operation,
	input  wire logic                 out_free,
	input  wire tmc_pkg::tmc_status_t status,
	output tmc_pkg::tmc_cmd_t         cmd,
	output logic                      in_stall,
	output logic                      out_load
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN     = 4'd1;
	localparam logic [3:0] S_PRESS_RD = 4'd2;
	localparam logic [3:0] S_PRESS_LD = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_WR_NEXT  = 4'd5;
	localparam logic [3:0] S_WR_POS   = 4'd6;
	localparam logic [3:0] S_WR_PRESS = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.wr = tmc_pkg::WR_NONE;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (operation) begin
						cmd.tick = 1'b1;
						state_d = S_DONE;
					end else begin
						cmd.power_init = 1'b1;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done)
					state_d = S_PRESS_RD;
			end
			S_PRESS_RD: begin
				cmd.press_rd = 1'b1;
				state_d = S_PRESS_LD;
			end
			S_PRESS_LD: begin
				cmd.press_ld = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = S_WR_NEXT;
			end
			S_WR_NEXT: begin
				cmd.wr = tmc_pkg::WR_NEXT;
				state_d = S_WR_POS;
			end
			S_WR_POS: begin
				cmd.wr = tmc_pkg::WR_POS;
				state_d = S_WR_PRESS;
			end
			S_WR_PRESS: begin
				cmd.wr = tmc_pkg::WR_PRESS;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

/* src/tmc_datapath.sv */
`default_nettype none
module tmc_datapath #(
	parameter int STORE_DEPTH = tmc_pkg::STORE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tmc_pkg::tmc_cmd_t cmd,
	input  wire tmc_pkg::tmc_cfg_t cfg,
	input  wire logic [7:0]        battery_sample,
	output tmc_pkg::tmc_status_t   status,
	output tmc_pkg::tmc_result_t   result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] FIRST_A = AW'(tmc_pkg::FIRST_CELL);
	localparam logic [AW-1:0] LAST_A  = AW'(tmc_pkg::LAST_CELL);

	// store: payload array plus written flags; an unwritten cell reads erased
	logic [7:0]             mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [7:0]             rd_data_q;
	logic                   rd_valid_q;

	logic [AW-1:0] pos_q;
	logic [AW-1:0] next_q;
	logic [AW-1:0] write_pos_q;
	logic [7:0]    idx_q;
	logic [7:0]    mode_index_q;
	logic [7:0]    press_q;
	logic [7:0]    tick_q;
	logic [7:0]    low_q;
	logic [7:0]    level_q;
	logic [1:0]    kind_q;

	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    rd;

	assign rd = rd_valid_q ? rd_data_q : tmc_pkg::ERASED;
	assign status.scan_done = (rd != tmc_pkg::ERASED) || (pos_q == LAST_A);

	// power-on decision
	logic [2:0] grp;
	logic [2:0] glen;
	logic [7:0] idx_w;
	logic [7:0] ramp;
	logic [7:0] lvl_g;
	logic       prog;
	logic [7:0] lvl_new;
	logic [7:0] idx_new;
	logic [1:0] kind_new;

	always_comb begin
		grp = (cfg.group_select >= 8'd2 && cfg.group_select <= 8'd7) ?
			cfg.group_select[2:0] : 3'd0;
		glen = tmc_pkg::group_len(grp);
		idx_w = (idx_q >= {5'd0, glen}) ? 8'd0 : idx_q;
		ramp = (cfg.ramp_setting > tmc_pkg::RAMP_LIMIT) ? 8'd255 : cfg.ramp_setting;
		lvl_g = tmc_pkg::group_level(grp, idx_w[2:0]);
		if ((grp == 3'd3 || grp == 3'd4) && idx_w == 8'd0)
			lvl_g = ramp;
		prog = (press_q >= tmc_pkg::PROG_FIRST) && (press_q < tmc_pkg::PROG_END);
		lvl_new = prog ? tmc_pkg::LVL_PROGRAM : lvl_g;
		idx_new = prog ? idx_q : idx_w;
		if (lvl_new == tmc_pkg::LVL_PROGRAM)
			kind_new = tmc_pkg::KIND_PROGRAM;
		else if (lvl_new == tmc_pkg::LVL_STROBE)
			kind_new = tmc_pkg::KIND_STROBE;
		else
			kind_new = tmc_pkg::KIND_STEADY;
	end

	// tick arithmetic
	logic [7:0] tick_n;
	logic [7:0] low_n;
	logic       tick_live;
	logic       low_read;
	logic       batt_off;

	assign tick_live = cmd.tick && (kind_q != tmc_pkg::KIND_OFF);
	assign tick_n = (tick_q == tmc_pkg::TICK_MAX) ? tick_q : tick_q + 8'd1;
	assign low_n = low_q + 8'd1;
	assign low_read = (tick_n == tmc_pkg::TICK_MAX) && (battery_sample < tmc_pkg::BATT_CRIT);
	assign batt_off = low_read && (low_n > tmc_pkg::BATT_LIMIT);

	always_comb begin
		case (1'b1)
			cmd.power_init: raddr = FIRST_A;
			cmd.scan:       raddr = pos_q + AW'(1);
			cmd.press_rd:   raddr = pos_q + AW'(1);
			default:        raddr = pos_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = write_pos_q;
		wdata = tmc_pkg::ERASED;
		case (cmd.wr)
			tmc_pkg::WR_NEXT: begin
				we = 1'b1;
				waddr = next_q;
				wdata = mode_index_q | tmc_pkg::FLAG_BIT;
			end
			tmc_pkg::WR_POS: begin
				we = 1'b1;
				waddr = pos_q;
				wdata = tmc_pkg::ERASED;
			end
			tmc_pkg::WR_PRESS: begin
				we = 1'b1;
				waddr = next_q + AW'(1);
				wdata = press_q;
			end
			default: begin
				// mode lock at the second tick
				if (tick_live && tick_n == tmc_pkg::LOCK_SECOND) begin
					we = 1'b1;
					waddr = write_pos_q;
					wdata = (cfg.memory_setting != 8'd1) ? mode_index_q : 8'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_data_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we)
				valid_q[waddr] <= 1'b1;
			rd_valid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= FIRST_A;
			next_q <= FIRST_A;
			write_pos_q <= FIRST_A;
			idx_q <= 8'd0;
			mode_index_q <= 8'd0;
			press_q <= 8'd0;
			tick_q <= 8'd0;
			low_q <= 8'd0;
			level_q <= 8'd0;
			kind_q <= tmc_pkg::KIND_STEADY;
		end else begin
			if (cmd.power_init) begin
				pos_q <= FIRST_A;
				press_q <= 8'd0;
				tick_q <= 8'd0;
				low_q <= 8'd0;
			end
			if (cmd.scan) begin
				if (rd != tmc_pkg::ERASED) begin
					idx_q <= rd;
				end else if (pos_q == LAST_A) begin
					// nothing saved: past the last cell, erased byte
					pos_q <= pos_q + AW'(1);
					idx_q <= tmc_pkg::ERASED;
				end else begin
					pos_q <= pos_q + AW'(1);
				end
			end
			if (cmd.press_rd)
				next_q <= (pos_q >= LAST_A) ? FIRST_A : pos_q + AW'(1);
			if (cmd.press_ld && (idx_q & tmc_pkg::FLAG_BIT) != 8'd0) begin
				idx_q <= (idx_q & tmc_pkg::IDX_MASK) + 8'd1;
				press_q <= (rd == tmc_pkg::ERASED) ? rd : rd + 8'd1;
			end
			if (cmd.decide) begin
				mode_index_q <= idx_new;
				write_pos_q <= next_q;
				level_q <= lvl_new;
				kind_q <= kind_new;
			end
			if (tick_live) begin
				tick_q <= (tick_n == tmc_pkg::TICK_MAX) ? tmc_pkg::CHECK_RELOAD : tick_n;
				if (low_read)
					low_q <= low_n;
				if (batt_off) begin
					level_q <= 8'd0;
					kind_q <= tmc_pkg::KIND_OFF;
				end else if (level_q == tmc_pkg::LVL_TURBO &&
					tick_n == cfg.stepdown_setting - 8'd1) begin
					level_q <= tmc_pkg::LVL_TURBO_LOW;
				end
			end
		end
	end

	always_comb begin
		result = '0;
		result.light_kind = kind_q;
		case (kind_q)
			tmc_pkg::KIND_STEADY: begin
				result.output_level = level_q;
				result.fast_pwm = (level_q > tmc_pkg::LVL_FAST_MIN) && (level_q != 8'd255);
			end
			tmc_pkg::KIND_STROBE: begin
				result.output_level = 8'd255;
				result.strobe_half_period = cfg.strobe_period_setting;
			end
			tmc_pkg::KIND_PROGRAM: begin
				result.output_level = tmc_pkg::LVL_PROGRAM_OUT;
				result.program_slot = 3'(press_q - tmc_pkg::PROG_FIRST);
			end
			default: result.output_level = 8'd0;
		endcase
	end

endmodule
`default_nettype wire

/* src/torch_mode_controller.sv */
// Power-on: after acceptance the store scan reads 1 to 58 cells, one read per cycle on the
// store port, then PRESS_RD, PRESS_LD, DECIDE, WR_NEXT, WR_POS and WR_PRESS; DONE registers
// the result once the output register is free. A one-second tick goes straight to DONE.
// Requests: one request in work at a time, the next accepted the cycle after the result
// is registered; an output stall holds a finished request in DONE and the input busy.
// Reset: state registers clear at once; store written flags clear, every cell reads 0xff.
`default_nettype none
module torch_mode_controller #(
	parameter int STORE_DEPTH = tmc_pkg::STORE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          operation,
	input  wire logic [7:0]                    battery_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         output_level,
	output logic                               fast_pwm,
	output logic [1:0]                         light_kind,
	output logic [7:0]                         strobe_half_period,
	output logic [2:0]                         program_slot,
	input  wire logic                          cfg_we,
	input  wire logic [tmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_data
);

	tmc_pkg::tmc_cfg_t    cfg_q;
	tmc_pkg::tmc_cmd_t    cmd;
	tmc_pkg::tmc_status_t status;
	tmc_pkg::tmc_result_t result;
	tmc_pkg::tmc_result_t res_q;
	logic                 out_valid_q;
	logic                 out_load;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tmc_pkg::CFG_GROUP:    cfg_q.group_select <= cfg_data;
				tmc_pkg::CFG_MEMORY:   cfg_q.memory_setting <= cfg_data;
				tmc_pkg::CFG_STEPDOWN: cfg_q.stepdown_setting <= cfg_data;
				tmc_pkg::CFG_STROBE:   cfg_q.strobe_period_setting <= cfg_data;
				tmc_pkg::CFG_RAMP:     cfg_q.ramp_setting <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	tmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.out_free  (out_free),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_load  (out_load)
	);

	tmc_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg_q),
		.battery_sample (battery_sample),
		.status         (status),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			res_q <= result;
	end

	assign out_valid          = out_valid_q;
	assign output_level       = res_q.output_level;
	assign fast_pwm           = res_q.fast_pwm;
	assign light_kind         = res_q.light_kind;
	assign strobe_half_period = res_q.strobe_half_period;
	assign program_slot       = res_q.program_slot;

	// a taken request keeps the input side busy until its result is registered
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && light_kind == tmc_pkg::KIND_OFF |-> output_level == 8'd0)
		else $error("shut off with light on");

	a_fast_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fast_pwm |-> light_kind == tmc_pkg::KIND_STEADY)
		else $error("fast pwm outside steady kind");

endmodule
`default_nettype wire
